@@ rtl/hds_pkg.sv @@
// ----------------------------------------------------------------------------
// hds_pkg
// Shared constants and types of the heightfield diffusion stencil unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hds_pkg;

	localparam int MAX_GRID   = 256;
	localparam int GRID_AW    = $clog2(MAX_GRID);
	localparam int GRID_W     = GRID_AW + 1;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;
	localparam int APB_AW     = 4;

	typedef enum logic [1:0] {
		REG_GRID_SIZE = 2'd0,
		REG_DIFF_GAIN = 2'd1,
		REG_VEL_GAIN  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [GRID_AW-1:0] x;
		logic [GRID_AW-1:0] z;
		logic               emit_a;
		logic               emit_b;
		logic               interior;
	} tag_t;

	typedef struct packed {
		logic               en;
		logic [GRID_AW-1:0] addr;
		logic [15:0]        data;
	} wb_t;

	typedef struct packed {
		logic               last;
		logic               vel_valid;
		logic [15:0]        vel_z;
		logic [15:0]        vel_x;
		logic [14:0]        new_height;
		logic [GRID_AW-1:0] cell_z;
		logic [GRID_AW-1:0] cell_x;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/hds_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hds_cfg_regs
// APB register file: grid size, diffusion gain and velocity gain.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [hds_pkg::APB_AW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output logic      [hds_pkg::GRID_W-1:0] grid_size,
	output logic      [15:0]                diffusion_gain,
	output logic signed [15:0]              velocity_gain
);
	import hds_pkg::*;

	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size      <= GRID_W'(MAX_GRID);
			diffusion_gain <= '0;
			velocity_gain  <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_GRID_SIZE: grid_size      <= pwdata[GRID_W-1:0];
				REG_DIFF_GAIN: diffusion_gain <= pwdata[15:0];
				REG_VEL_GAIN:  velocity_gain  <= $signed(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GRID_SIZE: prdata = 32'(grid_size);
			REG_DIFF_GAIN: prdata = 32'(diffusion_gain);
			REG_VEL_GAIN:  prdata = 32'(velocity_gain);
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/hds_line_store.sv @@
// ----------------------------------------------------------------------------
// hds_line_store
// Upper and middle row memories, two read ports each, one write port each,
// with write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_line_store (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [hds_pkg::GRID_AW-1:0] mid_addr_a,
	input  wire logic [hds_pkg::GRID_AW-1:0] mid_addr_b,
	input  wire logic [hds_pkg::GRID_AW-1:0] up_addr_a,
	input  wire logic [hds_pkg::GRID_AW-1:0] up_addr_b,
	input  wire hds_pkg::wb_t                wb,
	output logic [15:0]                      mid_rd_a,
	output logic [15:0]                      mid_rd_b,
	output logic [15:0]                      up_rd_a,
	output logic [15:0]                      up_rd_b
);
	import hds_pkg::*;

	logic [15:0] mid_mem [MAX_GRID];
	logic [15:0] up_mem  [MAX_GRID];
	logic [15:0] up_wdata;

	assign up_wdata = mid_rd_a;

	always_ff @(posedge clk) begin
		if (wb.en) begin
			mid_mem[wb.addr] <= wb.data;
			up_mem[wb.addr]  <= up_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_rd_a <= (wb.en && wb.addr == mid_addr_a) ? wb.data : mid_mem[mid_addr_a];
			mid_rd_b <= (wb.en && wb.addr == mid_addr_b) ? wb.data : mid_mem[mid_addr_b];
			up_rd_a  <= (wb.en && wb.addr == up_addr_a) ? up_wdata : up_mem[up_addr_a];
			up_rd_b  <= (wb.en && wb.addr == up_addr_b) ? up_wdata : up_mem[up_addr_b];
		end
	end

endmodule

`default_nettype wire

@@ rtl/hds_stencil_pipe.sv @@
// ----------------------------------------------------------------------------
// hds_stencil_pipe
// Three-stage stencil datapath: Laplacian and differences, gain multiplies,
// rounding and saturation. Issues the line store write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_stencil_pipe (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire hds_pkg::tag_t        tag_s0,
	input  wire logic signed [15:0]   hin_s0,
	input  wire logic [15:0]          mid_rd_a,
	input  wire logic [15:0]          mid_rd_b,
	input  wire logic [15:0]          up_rd_a,
	input  wire logic [15:0]          up_rd_b,
	input  wire logic [15:0]          diffusion_gain,
	input  wire logic signed [15:0]   velocity_gain,
	output hds_pkg::wb_t              wb,
	output logic [1:0]                inflight,
	output logic                      wr_a,
	output logic                      wr_b,
	output hds_pkg::res_t             res_a,
	output hds_pkg::res_t             res_b
);
	import hds_pkg::*;

	function automatic logic [15:0] sat16(input logic signed [20:0] v);
		logic [15:0] r;
		if (v > 21'sd32767)
			r = 16'h7FFF;
		else if (v < -21'sd32768)
			r = 16'h8000;
		else
			r = v[15:0];
		return r;
	endfunction

	logic               v_s1, v_s2, v_s3;
	tag_t               tag_s1, tag_s2, tag_s3;
	logic signed [15:0] hin_s1, hin_s2, hin_s3;
	logic signed [15:0] h_s2, h_s3;
	logic               wet_s2, wet_s3;
	logic signed [19:0] lap_s2;
	logic signed [16:0] dxn_s2, dzn_s2;
	logic signed [36:0] pd_s3;
	logic signed [32:0] px_s3, pz_s3;

	logic signed [15:0] h, hr, hu, hl;
	logic signed [19:0] lap_c;
	logic signed [16:0] dxn_c, dzn_c;
	logic               wet_c;
	logic signed [36:0] pd_c, pd_r;
	logic signed [32:0] px_c, pz_c, px_r, pz_r;
	logic signed [20:0] dh, vx_w, vz_w;
	logic signed [22:0] nh_w;
	logic [14:0]        nh_wet, nh_dry, nh_b;

	assign h  = $signed(mid_rd_a);
	assign hr = $signed(mid_rd_b);
	assign hu = $signed(up_rd_a);
	assign hl = $signed(up_rd_b);

	assign lap_c = 20'(hl) + 20'(hr) + 20'(hu) + 20'(hin_s1) - (20'(h) <<< 2);
	assign dxn_c = 17'(hl) - 17'(hr);
	assign dzn_c = 17'(hu) - 17'(hin_s1);
	assign wet_c = tag_s1.interior && (h > 16'sd0);

	assign wb.en   = v_s1;
	assign wb.addr = tag_s1.x;
	assign wb.data = hin_s1;

	assign pd_c = lap_s2 * $signed({1'b0, diffusion_gain});
	assign px_c = dxn_s2 * velocity_gain;
	assign pz_c = dzn_s2 * velocity_gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= tag_s0;
			hin_s1 <= hin_s0;
		end
		tag_s2 <= tag_s1;
		hin_s2 <= hin_s1;
		h_s2   <= h;
		wet_s2 <= wet_c;
		lap_s2 <= lap_c;
		dxn_s2 <= dxn_c;
		dzn_s2 <= dzn_c;
		tag_s3 <= tag_s2;
		hin_s3 <= hin_s2;
		h_s3   <= h_s2;
		wet_s3 <= wet_s2;
		pd_s3  <= pd_c;
		px_s3  <= px_c;
		pz_s3  <= pz_c;
	end

	assign inflight = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);

	assign pd_r = pd_s3 + 37'sd32768;
	assign dh   = $signed(pd_r[36:16]);
	assign nh_w = 23'(h_s3) + 23'(dh);
	assign px_r = px_s3 + 33'sd2048;
	assign pz_r = pz_s3 + 33'sd2048;
	assign vx_w = $signed(px_r[32:12]);
	assign vz_w = $signed(pz_r[32:12]);

	always_comb begin
		if (nh_w < 23'sd0)
			nh_wet = '0;
		else if (nh_w > 23'sd32767)
			nh_wet = 15'h7FFF;
		else
			nh_wet = nh_w[14:0];
		nh_dry = (h_s3 > 16'sd0) ? h_s3[14:0] : '0;
		nh_b   = (hin_s3 > 16'sd0) ? hin_s3[14:0] : '0;
	end

	always_comb begin
		res_a.cell_x     = tag_s3.x;
		res_a.cell_z     = tag_s3.z - GRID_AW'(1);
		res_a.new_height = wet_s3 ? nh_wet : nh_dry;
		res_a.vel_x      = wet_s3 ? sat16(vx_w) : '0;
		res_a.vel_z      = wet_s3 ? sat16(vz_w) : '0;
		res_a.vel_valid  = wet_s3;
		res_a.last       = !tag_s3.emit_b;

		res_b.cell_x     = tag_s3.x;
		res_b.cell_z     = tag_s3.z;
		res_b.new_height = nh_b;
		res_b.vel_x      = '0;
		res_b.vel_z      = '0;
		res_b.vel_valid  = 1'b0;
		res_b.last       = 1'b1;
	end

	assign wr_a = v_s3 && tag_s3.emit_a;
	assign wr_b = v_s3 && tag_s3.emit_b;

endmodule

`default_nettype wire

@@ rtl/hds_result_fifo.sv @@
// ----------------------------------------------------------------------------
// hds_result_fifo
// Result queue: up to two pushes per cycle, one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_result_fifo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_a,
	input  wire hds_pkg::res_t               res_a,
	input  wire logic                        wr_b,
	input  wire hds_pkg::res_t               res_b,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output hds_pkg::res_t                    out_res,
	output logic [hds_pkg::FIFO_CW-1:0]      count
);
	import hds_pkg::*;

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic [1:0]         nwr;
	logic               pop;

	assign nwr       = 2'(wr_a) + 2'(wr_b);
	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rptr_q];
	assign pop       = out_valid && out_ready;
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (wr_a)
			mem_q[wptr_q] <= res_a;
		if (wr_b)
			mem_q[wr_a ? wptr_q + FIFO_AW'(1) : wptr_q] <= res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + FIFO_AW'(nwr);
			rptr_q  <= rptr_q + FIFO_AW'(pop);
			count_q <= count_q + FIFO_CW'(nwr) - FIFO_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(FIFO_CW + 1)'(count_q) + (FIFO_CW + 1)'(nwr) <= (FIFO_CW + 1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue count out of range");

endmodule

`default_nettype wire

@@ rtl/heightfield_diffusion_stencil_unit.sv @@
// ----------------------------------------------------------------------------
// heightfield_diffusion_stencil_unit
// Five-point Laplacian water-height update over a raster-streamed grid.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tdata: height; tuser: frame_start
//   m_*       out  m_tvalid/m_tready  tdata: cell_x..vel_z; tuser: vel_valid;
//                                     tlast: run_last
//   apb       in   psel/penable       grid_size, diffusion_gain, velocity_gain
//
// One cell accepted per cycle while s_tready is high. Last-row cells give two
// results each, so there the output port sets the pace at one result per
// cycle while m_tready is high. The line stores take one read and one
// write-back per cell, with bypass on back-to-back columns.
// Reset clears the counters and the 16-entry result queue; line stores are
// not cleared. s_tready drops when the queue could not hold the results of
// all requests in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_diffusion_stencil_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [15:0]                s_tdata,   // [15:0] height
	input  wire logic [0:0]                 s_tuser,   // [0] frame_start
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [63:0]                     m_tdata,   // [7:0] cell_x, [15:8] cell_z,
	                                                   // [30:16] new_height,
	                                                   // [46:31] vel_x, [62:47] vel_z
	output logic [0:0]                      m_tuser,   // [0] vel_valid
	output logic                            m_tlast,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [hds_pkg::APB_AW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import hds_pkg::*;

	logic [GRID_W-1:0]  grid_size;
	logic [15:0]        diffusion_gain;
	logic signed [15:0] velocity_gain;

	logic [GRID_W-1:0]  grid_n;
	logic [GRID_AW-1:0] col_q, row_q;
	logic [GRID_AW-1:0] x, z;
	logic [GRID_W-1:0]  x_inc, z_inc;
	logic               accept;
	tag_t               tag_s0;

	wb_t                wb;
	logic [15:0]        mid_rd_a, mid_rd_b, up_rd_a, up_rd_b;
	logic [1:0]         inflight;
	logic               wr_a, wr_b;
	res_t               res_a, res_b, out_res;
	logic [FIFO_CW-1:0] fifo_count;
	logic [FIFO_CW:0]   reserve;

	hds_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.grid_size      (grid_size),
		.diffusion_gain (diffusion_gain),
		.velocity_gain  (velocity_gain)
	);

	always_comb begin
		if (grid_size == '0)
			grid_n = GRID_W'(1);
		else if (grid_size > GRID_W'(MAX_GRID))
			grid_n = GRID_W'(MAX_GRID);
		else
			grid_n = grid_size;
	end

	assign reserve  = (FIFO_CW + 1)'(fifo_count) + (FIFO_CW + 1)'({inflight, 1'b0});
	assign s_tready = reserve <= (FIFO_CW + 1)'(FIFO_DEPTH - 2);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		x = (s_tuser[0] || GRID_W'(col_q) >= grid_n) ? '0 : col_q;
		z = (s_tuser[0] || GRID_W'(row_q) >= grid_n) ? '0 : row_q;
		x_inc = GRID_W'(x) + GRID_W'(1);
		z_inc = GRID_W'(z) + GRID_W'(1);
		tag_s0.x        = x;
		tag_s0.z        = z;
		tag_s0.emit_a   = z != '0;
		tag_s0.emit_b   = z_inc == grid_n;
		tag_s0.interior = (z >= GRID_AW'(2)) && (x != '0) && (x_inc < grid_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (x_inc >= grid_n) begin
				col_q <= '0;
				row_q <= (z_inc >= grid_n) ? '0 : z_inc[GRID_AW-1:0];
			end else begin
				col_q <= x_inc[GRID_AW-1:0];
				row_q <= z;
			end
		end
	end

	hds_line_store u_store (
		.clk        (clk),
		.rd_en      (accept),
		.mid_addr_a (x),
		.mid_addr_b (x_inc[GRID_AW-1:0]),
		.up_addr_a  (x),
		.up_addr_b  (x - GRID_AW'(1)),
		.wb         (wb),
		.mid_rd_a   (mid_rd_a),
		.mid_rd_b   (mid_rd_b),
		.up_rd_a    (up_rd_a),
		.up_rd_b    (up_rd_b)
	);

	hds_stencil_pipe u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.tag_s0         (tag_s0),
		.hin_s0         ($signed(s_tdata)),
		.mid_rd_a       (mid_rd_a),
		.mid_rd_b       (mid_rd_b),
		.up_rd_a        (up_rd_a),
		.up_rd_b        (up_rd_b),
		.diffusion_gain (diffusion_gain),
		.velocity_gain  (velocity_gain),
		.wb             (wb),
		.inflight       (inflight),
		.wr_a           (wr_a),
		.wr_b           (wr_b),
		.res_a          (res_a),
		.res_b          (res_b)
	);

	hds_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_a      (wr_a),
		.res_a     (res_a),
		.wr_b      (wr_b),
		.res_b     (res_b),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.count     (fifo_count)
	);

	assign m_tdata = {1'b0, out_res.vel_z, out_res.vel_x, out_res.new_height,
		out_res.cell_z, out_res.cell_x};
	assign m_tuser = out_res.vel_valid;
	assign m_tlast = out_res.last;

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser[0] && grid_n > GRID_W'(1)) |=> (col_q == GRID_AW'(1) && row_q == '0))
		else $error("frame start did not restart the position counters");

endmodule

`default_nettype wire
